// ===== rtl/insertion_sorter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Insertion sorter assertion macros
// Shared property macros, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");

// The consequent must hold in the cycle after the antecedent.
`define IST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");

`endif

// ===== rtl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared widths, default depth and the control word of the sorting cells.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int DataW       = 32;
  localparam int MaxItemsDef = 16;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic                    ins;    // insert value into the chain
    logic                    shl;    // shift the chain toward cell 0
    logic signed [DataW-1:0] value;  // value being inserted
  } cell_ctl_t;

endpackage

// ===== rtl/ist_if.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter channels
// Valid/ready channels for the input words and the sorted result words.
// ----------------------------------------------------------------------------
interface ist_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ist_pkg::DataW-1:0] value;
  logic                            last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface ist_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [ist_pkg::DataW-1:0] sorted_value;
  logic                            last_out;
  logic                            overflow;

  modport source (output valid, output sorted_value, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input overflow, output ready);
endinterface

// ===== rtl/ist_cell.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter cell
// One slot of the sorted chain: compares against the broadcast value and
// takes its left neighbor, the new value or its right neighbor, or keeps its own.
// ----------------------------------------------------------------------------
module ist_cell (
  input  logic                             clk_i,
  input  ist_pkg::cell_ctl_t               ctl_i,
  input  logic                             occ_i,
  input  logic                             left_occ_i,
  input  logic                             left_gt_i,
  input  logic signed [ist_pkg::DataW-1:0] left_val_i,
  input  logic signed [ist_pkg::DataW-1:0] right_val_i,
  output logic                             gt_o,
  output logic signed [ist_pkg::DataW-1:0] val_o
);

  logic signed [ist_pkg::DataW-1:0] val_q, val_d;

  // Strictly greater, so an equal new value lands behind this entry.
  assign gt_o  = occ_i && (val_q > ctl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shl) begin
      val_d = right_val_i;
    end else if (ctl_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || (!occ_i && left_occ_i)) begin
        val_d = ctl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// Insertion sorter unit
// Stable batch sorter for signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage: words arrive on in_i, one value each. Every accepted word is placed
// into its sorted position in the cell chain by a single register update, so the block
// takes one input word per cycle while collecting a batch. Equal values keep
// their arrival order. A word with last_in set closes the batch: it is
// inserted first, and from the next cycle the chain drains through out_o in
// ascending order, one word per cycle that the receiver takes. The final word
// carries last_out, and every word of the batch carries overflow if any word
// was dropped because all MaxItems cells were full. The drain is set by the
// single shift path out of cell 0, and in_i is held off while it runs. When
// the receiver stalls, cell 0 simply holds the current word and the chain
// waits. Reset clears the fill count, the overflow flag and the drain state;
// the cell contents need no reset because only filled cells are ever read.
// ----------------------------------------------------------------------------
module insertion_sorter_unit #(
  parameter int MaxItems = ist_pkg::MaxItemsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ist_in_if.sink    in_i,
  ist_out_if.source out_o
);

  localparam int CntW = $clog2(MaxItems + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            drain_q, drain_d;
  logic            ovf_q, ovf_d;

  logic full;
  logic in_acc;
  logic out_acc;

  ist_pkg::cell_ctl_t ctl;

  logic signed [ist_pkg::DataW-1:0] val [MaxItems];
  logic [MaxItems-1:0]              gt;
  logic [MaxItems-1:0]              occ;

  assign full    = (count_q == CntW'(MaxItems));
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Collecting and draining never overlap.
  assign in_i.ready = !drain_q;

  assign ctl.ins   = in_acc && !full;
  assign ctl.shl   = out_acc;
  assign ctl.value = in_i.value;

  // The chain: cell 0 holds the smallest value. A cell is filled when its
  // index is below the fill count.
  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      ist_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .occ_i      (occ[i]),
        .left_occ_i (1'b1),
        .left_gt_i  (1'b0),
        .left_val_i ('0),
        .right_val_i(val[i+1]),
        .gt_o       (gt[i]),
        .val_o      (val[i])
      );
    end else if (i == MaxItems - 1) begin : g_tail
      ist_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .occ_i      (occ[i]),
        .left_occ_i (occ[i-1]),
        .left_gt_i  (gt[i-1]),
        .left_val_i (val[i-1]),
        .right_val_i(val[i]),
        .gt_o       (gt[i]),
        .val_o      (val[i])
      );
    end else begin : g_mid
      ist_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .occ_i      (occ[i]),
        .left_occ_i (occ[i-1]),
        .left_gt_i  (gt[i-1]),
        .left_val_i (val[i-1]),
        .right_val_i(val[i+1]),
        .gt_o       (gt[i]),
        .val_o      (val[i])
      );
    end
  end

  // Batch control: the count tracks filled cells while collecting and the
  // words still to send while draining.
  always_comb begin
    count_d = count_q;
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (in_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
      if (in_i.last_in) begin
        drain_d = 1'b1;
      end
    end
    if (out_acc) begin
      count_d = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_o.valid        = drain_q;
  assign out_o.sorted_value = val[0];
  assign out_o.last_out     = (count_q == CntW'(1));
  assign out_o.overflow     = ovf_q;

  `include "insertion_sorter_unit_assert.svh"

  `IST_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CntW'(MaxItems))
  `IST_ASSERT_SAME(a_drain_nonempty, drain_q, count_q != '0)
  `IST_ASSERT_NEXT(a_batch_closed, out_acc && out_o.last_out,
                   !drain_q && (count_q == '0) && !ovf_q)
  `IST_ASSERT_NEXT(a_ascending, out_acc && !out_o.last_out,
                   out_o.sorted_value >= $past(out_o.sorted_value))
  `IST_ASSERT_NEXT(a_ovf_steady, drain_q && !out_acc, ovf_q == $past(ovf_q))

endmodule
